### rtl/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;

	localparam int DataW   = 32;
	localparam int HalfW   = 16;
	localparam int DivSteps = DataW;
	localparam int CfgIdxW = 3;
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);

	localparam logic [CfgIdxW-1:0] CfgAc1Ac2 = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgAc3Ac4 = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgAc5Ac6 = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgB1B2   = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgMcMd   = 3'd4;
	localparam logic [CfgIdxW-1:0] CfgOss    = 3'd5;

	localparam logic [DataW-1:0] TempOffset  = 32'd4000;
	localparam logic [DataW-1:0] HalfScale   = 32'd32768;
	localparam logic [DataW-1:0] PressScale  = 32'd50000;
	localparam logic [DataW-1:0] CoefSquare  = 32'd3038;
	localparam logic [DataW-1:0] CoefLinear  = 32'hFFFF_E343;  // -7357
	localparam logic [DataW-1:0] CoefOffset  = 32'd3791;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press_bytes;
	} req_t;

	typedef struct packed {
		logic signed [31:0] temp_tenths;
		logic signed [31:0] pressure_pa;
		logic               div_fault;
	} rsp_t;

	// calibration words, each already extended to the datapath width
	typedef struct packed {
		logic [DataW-1:0] ac1;
		logic [DataW-1:0] ac2;
		logic [DataW-1:0] ac3;
		logic [DataW-1:0] ac4;
		logic [DataW-1:0] ac5;
		logic [DataW-1:0] ac6;
		logic [DataW-1:0] b1;
		logic [DataW-1:0] b2;
		logic [DataW-1:0] mc;
		logic [DataW-1:0] md;
		logic [1:0]       oss;
	} cal_t;

	// queue entry between front and back
	typedef struct packed {
		logic [DataW-1:0] diff;
		logic [DataW-1:0] up;
		logic [1:0]       oss;
	} work_t;

	// sideband that rides along a divider
	typedef struct packed {
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [1:0]       oss;
		logic             f;
		logic             g;
	} side_t;

	function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v, input int k);
		logic signed [DataW-1:0] s;
		s = $signed(v) >>> k;
		return s;
	endfunction

	function automatic logic [DataW-1:0] sx16(input logic [HalfW-1:0] v);
		return {{(DataW-HalfW){v[HalfW-1]}}, v};
	endfunction

	function automatic logic [DataW-1:0] zx16(input logic [HalfW-1:0] v);
		return {{(DataW-HalfW){1'b0}}, v};
	endfunction

endpackage

### rtl/barometric_pressure_compensation_core.sv
`timescale 1ns / 1ps
// Barometric sensor compensation: raw temperature word and raw pressure
// bytes in, temperature in tenths of a degree and pressure in pascals out.
// Request channel: req_valid / req_stall carrying req. A transaction is
// taken when req_valid is high and req_stall is low. Response channel:
// rsp_valid / rsp_stall carrying rsp, taken the same way.
// Calibration words and oversampling are written through cfg_we,
// cfg_index and cfg_data, only while no transaction is in flight, a
// user rule the block does not enforce. A four-entry queue sits between
// the input front and the compute back. Throughput is one transaction
// per cycle while rsp_stall does not hold the back; most of the delay
// is in the 32-stage pipelined temperature and pressure dividers.
// A zero divisor gives div_fault with both results zero.
// When rsp_stall is high with rsp_valid set, the whole back pipeline
// holds; the queue takes requests until full, then req_stall rises.
// Reset clears calibration registers, the queue and all valid flags.
module barometric_pressure_compensation_core import bpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data
);

	logic [DataW-1:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]       oss_q;
	cal_t             cal;
	logic             push, full, pop, pop_valid;
	work_t            push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgAc1Ac2: ac12_q <= cfg_data;
				CfgAc3Ac4: ac34_q <= cfg_data;
				CfgAc5Ac6: ac56_q <= cfg_data;
				CfgB1B2:   b12_q  <= cfg_data;
				CfgMcMd:   mcmd_q <= cfg_data;
				CfgOss:    oss_q  <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		cal.ac1 = sx16(ac12_q[31:16]);
		cal.ac2 = sx16(ac12_q[15:0]);
		cal.ac3 = sx16(ac34_q[31:16]);
		cal.ac4 = zx16(ac34_q[15:0]);
		cal.ac5 = zx16(ac56_q[31:16]);
		cal.ac6 = zx16(ac56_q[15:0]);
		cal.b1  = sx16(b12_q[31:16]);
		cal.b2  = sx16(b12_q[15:0]);
		cal.mc  = sx16(mcmd_q[31:16]);
		cal.md  = sx16(mcmd_q[15:0]);
		cal.oss = oss_q;
	end

	assign req_stall = full;

	bpc_front u_front (
		.req_valid (req_valid),
		.req       (req),
		.cal       (cal),
		.push      (push),
		.push_data (push_data)
	);

	bpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	bpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cal        (cal),
		.work_valid (pop_valid),
		.work       (pop_data),
		.work_pop   (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

### rtl/bpc_front.sv
`timescale 1ns / 1ps
module bpc_front import bpc_pkg::*; (
	input  logic  req_valid,
	input  req_t  req,
	input  cal_t  cal,
	output logic  push,
	output work_t push_data
);

	logic [DataW-1:0] press_ext;

	always_comb begin
		press_ext       = {{(DataW-24){1'b0}}, req.raw_press_bytes};
		push            = req_valid;
		push_data.diff  = zx16(req.raw_temp) - cal.ac6;
		push_data.up    = press_ext >> (4'd8 - {2'b00, cal.oss});
		push_data.oss   = cal.oss;
	end

endmodule

### rtl/bpc_fifo.sv
`timescale 1ns / 1ps
module bpc_fifo import bpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  pop_valid,
	output work_t pop_data
);

	work_t                mem_q [FifoDepth];
	logic [FifoPtrW-1:0]  wptr_q, rptr_q;
	logic [FifoPtrW:0]    count_q;
	logic                 do_push, do_pop;

	always_comb begin
		full      = (count_q == (FifoPtrW+1)'(FifoDepth));
		pop_valid = (count_q != '0);
		pop_data  = mem_q[rptr_q];
		do_push   = push && !full;
		do_pop    = pop && pop_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_data;
	end

endmodule

### rtl/bpc_div.sv
`timescale 1ns / 1ps
module bpc_div import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [DataW-1:0] dividend,
	input  logic [DataW-1:0] divisor,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [DataW-1:0] quotient,
	output side_t            out_side
);

	// one quotient bit per stage, restoring
	logic             vld_s  [DivSteps];
	logic [DataW-1:0] rem_s  [DivSteps];
	logic [DataW-1:0] nq_s   [DivSteps];
	logic [DataW-1:0] den_s  [DivSteps];
	side_t            side_s [DivSteps];

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		logic             pv;
		logic [DataW-1:0] prem, pnq, pden;
		side_t            pside;
		logic [DataW:0]   sh, sub;
		logic             ge;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign pnq   = dividend;
			assign pden  = divisor;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[i-1];
			assign prem  = rem_s[i-1];
			assign pnq   = nq_s[i-1];
			assign pden  = den_s[i-1];
			assign pside = side_s[i-1];
		end

		always_comb begin
			sh  = {prem, pnq[DataW-1]};
			sub = sh - {1'b0, pden};
			ge  = (sh >= {1'b0, pden});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (adv) vld_s[i] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i]  <= ge ? sub[DataW-1:0] : sh[DataW-1:0];
				nq_s[i]   <= {pnq[DataW-2:0], ge};
				den_s[i]  <= pden;
				side_s[i] <= pside;
			end
		end
	end

	assign out_valid = vld_s[DivSteps-1];
	assign quotient  = nq_s[DivSteps-1];
	assign out_side  = side_s[DivSteps-1];

endmodule

### rtl/bpc_back.sv
`timescale 1ns / 1ps
module bpc_back import bpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cal_t  cal,
	input  logic  work_valid,
	input  work_t work,
	output logic  work_pop,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	logic adv;

	logic             v_s1;
	logic [DataW-1:0] prod_s1, up_s1;
	logic [1:0]       oss_s1;

	logic [DataW-1:0] x1t, den, mcs, d1_num, d1_den;
	side_t            d1_in, d1_out;
	logic             d1_v;
	logic [DataW-1:0] d1_q, x2t, b5;

	logic             v_s3, f_s3;
	logic [DataW-1:0] t_s3, b6_s3, up_s3;
	logic [1:0]       oss_s3;

	logic             v_s4, f_s4;
	logic [DataW-1:0] t_s4, up_s4, sq_s4, mac2_s4, mac3_s4;
	logic [1:0]       oss_s4;

	logic             v_s5, f_s5;
	logic [DataW-1:0] t_s5, up_s5, mac2_s5, mac3_s5, mb1_s5, mb2_s5, b6sq;
	logic [1:0]       oss_s5;

	logic             v_s6, f_s6;
	logic [DataW-1:0] t_s6, up_s6, b3_s6, x3_s6, x3a, b3p;
	logic [1:0]       oss_s6;

	logic             v_s7, f_s7;
	logic [DataW-1:0] t_s7, b4_s7, b7_s7;

	side_t            d2_in, d2_out;
	logic             d2_v;
	logic [DataW-1:0] d2_num, d2_q, p, ps;

	logic             v_s8, f_s8;
	logic [DataW-1:0] t_s8, p_s8, sq_s8, x2_s8;

	logic             v_s9, f_s9;
	logic [DataW-1:0] t_s9, p_s9, x1_s9, x2_s9, pfin;

	assign adv      = !rsp_valid || !rsp_stall;
	assign work_pop = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= work_valid; v_s3 <= d1_v; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= d2_v; v_s9 <= v_s8;
			rsp_valid <= v_s9;
		end
	end

	// temperature: (UT - AC6) * AC5
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= work.diff * cal.ac5;
			up_s1   <= work.up;
			oss_s1  <= work.oss;
		end
	end

	// signed MC<<11 / (X1 + MD) through the unsigned divider
	always_comb begin
		x1t      = asr(prod_s1, 15);
		den      = x1t + cal.md;
		mcs      = cal.mc << 11;
		d1_num   = mcs[DataW-1] ? (32'd0 - mcs) : mcs;
		d1_den   = den[DataW-1] ? (32'd0 - den) : den;
		d1_in.a  = x1t;
		d1_in.b  = up_s1;
		d1_in.oss = oss_s1;
		d1_in.f  = (den == '0);
		d1_in.g  = mcs[DataW-1] ^ den[DataW-1];
	end

	bpc_div u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s1),
		.dividend  (d1_num),
		.divisor   (d1_den),
		.in_side   (d1_in),
		.out_valid (d1_v),
		.quotient  (d1_q),
		.out_side  (d1_out)
	);

	always_comb begin
		x2t = d1_out.g ? (32'd0 - d1_q) : d1_q;
		b5  = d1_out.a + x2t;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3   <= asr(b5 + 32'd8, 4);
			b6_s3  <= b5 - TempOffset;
			up_s3  <= d1_out.b;
			oss_s3 <= d1_out.oss;
			f_s3   <= d1_out.f;

			t_s4    <= t_s3;
			up_s4   <= up_s3;
			oss_s4  <= oss_s3;
			f_s4    <= f_s3;
			sq_s4   <= b6_s3 * b6_s3;
			mac2_s4 <= cal.ac2 * b6_s3;
			mac3_s4 <= cal.ac3 * b6_s3;

			t_s5    <= t_s4;
			up_s5   <= up_s4;
			oss_s5  <= oss_s4;
			f_s5    <= f_s4;
			mac2_s5 <= mac2_s4;
			mac3_s5 <= mac3_s4;
			mb2_s5  <= cal.b2 * b6sq;
			mb1_s5  <= cal.b1 * b6sq;

			t_s6   <= t_s5;
			up_s6  <= up_s5;
			oss_s6 <= oss_s5;
			f_s6   <= f_s5;
			b3_s6  <= asr(b3p + 32'd2, 2);
			x3_s6  <= asr(asr(mac3_s5, 13) + asr(mb1_s5, 16) + 32'd2, 2);

			t_s7  <= t_s6;
			f_s7  <= f_s6;
			b4_s7 <= (cal.ac4 * (x3_s6 + HalfScale)) >> 15;
			b7_s7 <= (up_s6 - b3_s6) * (PressScale >> oss_s6);
		end
	end

	always_comb begin
		b6sq = asr(sq_s4, 12);
		x3a  = asr(mb2_s5, 11) + asr(mac2_s5, 11);
		b3p  = ((cal.ac1 << 2) + x3a) << oss_s5;
	end

	// pressure quotient: double before dividing unless the top bit is set
	always_comb begin
		d2_num    = b7_s7[DataW-1] ? b7_s7 : (b7_s7 << 1);
		d2_in.a   = t_s7;
		d2_in.b   = '0;
		d2_in.oss = '0;
		d2_in.f   = f_s7 || (b4_s7 == '0);
		d2_in.g   = b7_s7[DataW-1];
	end

	bpc_div u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s7),
		.dividend  (d2_num),
		.divisor   (b4_s7),
		.in_side   (d2_in),
		.out_valid (d2_v),
		.quotient  (d2_q),
		.out_side  (d2_out)
	);

	always_comb begin
		p  = d2_out.g ? (d2_q << 1) : d2_q;
		ps = asr(p, 8);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s8  <= d2_out.a;
			f_s8  <= d2_out.f;
			p_s8  <= p;
			sq_s8 <= ps * ps;
			x2_s8 <= CoefLinear * p;

			t_s9  <= t_s8;
			f_s9  <= f_s8;
			p_s9  <= p_s8;
			x2_s9 <= x2_s8;
			x1_s9 <= sq_s8 * CoefSquare;
		end
	end

	assign pfin = p_s9 + asr(asr(x1_s9, 16) + asr(x2_s9, 16) + CoefOffset, 4);

	// drop both results on a zero divisor
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.temp_tenths <= f_s9 ? '0 : $signed(t_s9);
			rsp.pressure_pa <= f_s9 ? '0 : $signed(pfin);
			rsp.div_fault   <= f_s9;
		end
	end

endmodule
